>>> design/mss_pkg.sv
// Shared types and constants for the multi-stack shared store.
package mss_pkg;

   // Width of the stack number field and the number of addressable stacks
   localparam int SID_W       = 2;
   localparam int STACK_SLOTS = 1 << SID_W;
   localparam int DATA_W      = 32;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } mss_state_type;

   // Request payload
   typedef struct packed {
      logic                     op;
      logic [SID_W-1:0]         stack_id;
      logic signed [DATA_W-1:0] value;
   } mss_req_type;

   // Response payload
   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
   } mss_rsp_type;

endpackage

>>> design/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/multi_stack_shared_store_core.sv
// Top level: several LIFO stacks sharing one data store through a linked free list.
//
// Usage:
//   Request channel: drive req_item and raise start; the request is taken at a
//   rising edge where start is high and busy is low. op selects push or pop of
//   the addressed stack; value is ignored on a pop.
//   Response channel: every request yields one response, shown on rsp_item for
//   exactly one cycle with rsp_strobe high. The receiver cannot stall it.
//   Timing: a taken request moves the sequencer to the execute state, whose
//   end registers the response. busy is high in the execute state, entered in the cycle
//   after a request is taken, so a new request can be taken in the cycle its predecessor's
//   response shows. The execute state serves the link RAM: the top or free
//   pointer picks the link entry, whose registered read data updates the lists.
//   Status: ok, full (push with no free slot or stack out of range), or empty
//   (pop of an empty or out-of-range stack); popped_value is zero unless a pop
//   succeeds.
//   Reset: all stacks empty, every slot free. The free chain is built lazily by
//   a fill count, so no clearing pass runs and requests are taken right away.
module multi_stack_shared_store_core #(
   parameter int NUM_STACKS  = 4,
   parameter int STORE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mss_pkg::mss_req_type req_item,
   output logic                 rsp_strobe,
   output mss_pkg::mss_rsp_type rsp_item
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int PTR_W = AW + 1;
   localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(STORE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);

   // Sequencer and request registers
   mss_pkg::mss_state_type          state_ff, state_in;
   logic                            op_ff;
   logic [mss_pkg::SID_W-1:0]       sid_ff;
   logic [mss_pkg::DATA_W-1:0]      value_ff;
   logic [PTR_W-1:0]                ptr_ff;
   logic                            ok_ff;

   // List state
   logic [PTR_W-1:0]                tops_ff [mss_pkg::STACK_SLOTS];
   logic [PTR_W-1:0]                tops_in [mss_pkg::STACK_SLOTS];
   logic [PTR_W-1:0]                free_head_ff, free_head_in;
   logic [PTR_W-1:0]                fill_ff, fill_in;

   // Response registers
   logic                            rsp_strobe_ff, rsp_strobe_in;
   mss_pkg::mss_rsp_type            rsp_item_ff, rsp_item_in;

   // Decode and RAM signals
   logic                            accept;
   logic                            exists;
   logic [PTR_W-1:0]                ptr_sel;
   logic                            ok_sel;
   logic [PTR_W-1:0]                link_rd;
   logic [mss_pkg::DATA_W-1:0]      data_rd;
   logic                            fresh;
   logic [PTR_W-1:0]                link_val;
   logic                            link_we;
   logic [PTR_W-1:0]                link_wdata;
   logic                            data_we;

   assign accept = start && (state_ff == mss_pkg::ST_IDLE);
   assign busy   = (state_ff == mss_pkg::ST_EXEC);

   // Pointer selection at request time: top of stack for pop, free head for push
   always_comb begin
      exists  = (32'(req_item.stack_id) < 32'(NUM_STACKS));
      ptr_sel = (req_item.op == mss_pkg::OP_POP) ? tops_ff[req_item.stack_id]
                                                 : free_head_ff;
      ok_sel  = exists && (ptr_sel < PTR_NULL);
   end

   // Slots at or above the fill count were never written: their link is i+1, or null for the last slot
   always_comb begin
      fresh    = (ptr_ff >= fill_ff);
      link_val = link_rd;
      if (fresh) begin
         link_val = (ptr_ff == PTR_LAST) ? PTR_NULL : ptr_ff + PTR_W'(1);
      end
   end

   // RAM write controls during execution
   always_comb begin
      link_we    = busy && ok_ff;
      data_we    = busy && ok_ff && (op_ff == mss_pkg::OP_PUSH);
      link_wdata = (op_ff == mss_pkg::OP_PUSH) ? tops_ff[sid_ff] : free_head_ff;
   end

   mss_ram #(
      .WIDTH (PTR_W),
      .DEPTH (STORE_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (ptr_sel[AW-1:0]),
      .rd_data (link_rd)
   );

   mss_ram #(
      .WIDTH (mss_pkg::DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (accept),
      .rd_addr (ptr_sel[AW-1:0]),
      .rd_data (data_rd)
   );

   // Next state, list updates and response
   always_comb begin
      state_in      = state_ff;
      tops_in       = tops_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      case (state_ff)
         mss_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mss_pkg::ST_EXEC;
            end
         end
         mss_pkg::ST_EXEC: begin
            state_in                 = mss_pkg::ST_IDLE;
            rsp_strobe_in            = 1'b1;
            rsp_item_in.status       = mss_pkg::ST_OK;
            rsp_item_in.popped_value = '0;
            if (!ok_ff) begin
               rsp_item_in.status = (op_ff == mss_pkg::OP_PUSH) ? mss_pkg::ST_FULL
                                                                : mss_pkg::ST_EMPTY;
            end else if (op_ff == mss_pkg::OP_PUSH) begin
               free_head_in    = link_val;
               tops_in[sid_ff] = ptr_ff;
               if (fresh) begin
                  fill_in = fill_ff + PTR_W'(1);
               end
            end else begin
               tops_in[sid_ff]          = link_val;
               free_head_in             = ptr_ff;
               rsp_item_in.popped_value = signed'(data_rd);
            end
         end
         default: begin
            state_in = mss_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mss_pkg::ST_IDLE;
         free_head_ff  <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < mss_pkg::STACK_SLOTS; i++) begin
            tops_ff[i] <= PTR_NULL;
         end
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
         tops_ff       <= tops_in;
      end
   end

   // Request and response payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_item.op;
         sid_ff   <= req_item.stack_id;
         value_ff <= $unsigned(req_item.value);
         ptr_ff   <= ptr_sel;
         ok_ff    <= ok_sel;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTH
   // A taken request always leads to the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request taken without execute cycle");

   // Execute cycle always produces a response on the next cycle
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("execute cycle without response");

   // A response follows only an execute cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without execute cycle");

   // Fill count never passes the store size
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PTR_NULL)
      else $error("fill count out of range");

   // A successful push leaves its slot on top of the addressed stack
   a_push_top: assert property (@(posedge clock) disable iff (reset)
      (busy && ok_ff && (op_ff == mss_pkg::OP_PUSH)) |=>
         (tops_ff[$past(sid_ff)] == $past(ptr_ff)))
      else $error("push did not update stack top");
`endif

endmodule
